// ----- sv/chte_pkg.sv -----
// ---------------------------------------------------------------------------
// chte_pkg
// Shared types and codes of the chained hash table engine.
// ---------------------------------------------------------------------------
package chte_pkg;

  // Fixed field widths of the response and configuration beats, and the divider digit width
  localparam int CFG_WIDTH  = 5;
  localparam int IDX_WIDTH  = 8;
  localparam int DIGIT_BITS = 4;

  localparam logic [CFG_WIDTH-1:0] BUCKET_COUNT_RESET = 5'd16;

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  // Response status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_INSERTED  = 2'd0;
  localparam status_t ST_FOUND     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // Sequencer states
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_HRD   = 8'b0000_1000,
    S_HCHK  = 8'b0001_0000,
    S_NRD   = 8'b0010_0000,
    S_NCHK  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage

// ----- sv/chte_if.sv -----
// ---------------------------------------------------------------------------
// chte_if
// Valid/ready channels of the chained hash table engine: request,
// response and configuration write.
// ---------------------------------------------------------------------------
interface chte_in_if #(
  parameter int KEY_WIDTH = 31
) ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface chte_out_if ();
  logic                                   valid;
  logic                                   ready;
  chte_pkg::status_t                      status;
  logic [chte_pkg::IDX_WIDTH-1:0]         node_index;

  modport source (output valid, output status, output node_index, input ready);
  modport sink   (input valid, input status, input node_index, output ready);
endinterface

interface chte_cfg_if ();
  logic                           valid;
  logic                           ready;
  logic [chte_pkg::CFG_WIDTH-1:0] bucket_count;

  modport source (output valid, output bucket_count, input ready);
  modport sink   (input valid, input bucket_count, output ready);
endinterface

// ----- sv/chained_hash_table_engine.sv -----
// ---------------------------------------------------------------------------
// chained_hash_table_engine
// Hash table with separate chaining over a fixed node pool.
// ---------------------------------------------------------------------------
// One request is handled at a time; in_req.ready is high only while the
// engine is idle. The bucket is the key modulo the configured bucket count,
// clamped to 1..MAX_BUCKETS, found by a restoring divider that retires four
// key bits a cycle over ceil(KEY_WIDTH/4) digits (8 at the default width).
// An insert then reads the bucket head, writes the link and loads the
// response register. A find takes the divide, a head read and check, then a
// read and a compare per chain node visited on the single node memory port,
// then the response. After reset a clearing pass over all MAX_BUCKETS bucket
// heads empties them before the first request is taken; configuration
// writes are taken at any time. Nodes are handed out in order and never
// freed; a full pool refuses inserts with status 3.
// ---------------------------------------------------------------------------
module chained_hash_table_engine #(
  parameter int MAX_BUCKETS = 16,
  parameter int NODE_COUNT  = 256,
  parameter int KEY_WIDTH   = 31
) (
  input  logic            clk,
  input  logic            rst_n,
  chte_in_if.sink         in_req,
  chte_out_if.source      out_rsp,
  chte_cfg_if.sink        cfg_wr
);
  import chte_pkg::*;

  localparam int NW     = $clog2(NODE_COUNT + 1);
  localparam int AW     = $clog2(NODE_COUNT);
  localparam int BW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DIGITS = (KEY_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int KP     = DIGITS * DIGIT_BITS;
  localparam int DCW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int NODE_W = NW + KEY_WIDTH;

  localparam logic [NW-1:0]  NULL_NODE = NW'(NODE_COUNT);
  localparam logic [NW-1:0]  LAST_STEP = NW'(NODE_COUNT - 1);
  localparam logic [BW-1:0]  LAST_BKT  = BW'(MAX_BUCKETS - 1);
  localparam logic [DCW-1:0] LAST_DIG  = DCW'(DIGITS - 1);

  // Storage
  logic [NW-1:0]     head_mem [MAX_BUCKETS];
  logic [NODE_W-1:0] node_mem [NODE_COUNT];

  // Control and datapath registers
  state_t                 state_r;
  logic [CFG_WIDTH-1:0]   bucket_count_r;
  logic [CFG_WIDTH-1:0]   div_r;
  logic [CFG_WIDTH-1:0]   rem_r;
  logic [CFG_WIDTH-1:0]   rem_nxt;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [KP-1:0]          key_sh_r;
  logic [DCW-1:0]         dig_r;
  logic                   opcode_r;
  logic [BW-1:0]          bucket_r;
  logic [BW-1:0]          clr_r;
  logic [NW-1:0]          nodes_used_r;
  logic [NW-1:0]          cur_r;
  logic [NW-1:0]          steps_r;
  logic [NW-1:0]          head_q_r;
  logic [NODE_W-1:0]      node_q_r;
  status_t                res_status_r;
  logic [NW-1:0]          res_index_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [IDX_WIDTH-1:0]   out_index_r;

  logic [CFG_WIDTH-1:0]   div_eff;
  logic [CFG_WIDTH-1:0]   rem_v;
  logic [CFG_WIDTH:0]     trial;
  logic [NW-1:0]          node_next;
  logic [KEY_WIDTH-1:0]   node_key;
  logic                   link_we;

  assign node_next = node_q_r[NODE_W-1 -: NW];
  assign node_key  = node_q_r[KEY_WIDTH-1:0];
  assign link_we   = (state_r == S_HCHK) && (opcode_r == OP_INSERT);

  // Clamp the configured bucket count into 1..MAX_BUCKETS
  always_comb begin
    if (bucket_count_r == '0) begin
      div_eff = CFG_WIDTH'(1);
    end else if (int'(bucket_count_r) > MAX_BUCKETS) begin
      div_eff = CFG_WIDTH'(MAX_BUCKETS);
    end else begin
      div_eff = bucket_count_r;
    end
  end

  // Restoring divider: retire one digit of key bits per cycle
  always_comb begin
    rem_v = rem_r;
    trial = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      trial = {rem_v, key_sh_r[KP-1-i]};
      if (trial >= {1'b0, div_r}) begin
        rem_v = CFG_WIDTH'(trial - {1'b0, div_r});
      end else begin
        rem_v = trial[CFG_WIDTH-1:0];
      end
    end
    rem_nxt = rem_v;
  end

  // Bucket head memory: clearing pass, link on insert, registered read
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      head_mem[clr_r] <= NULL_NODE;
    end else if (link_we) begin
      head_mem[bucket_r] <= nodes_used_r;
    end
    if (state_r == S_HRD) begin
      head_q_r <= head_mem[bucket_r];
    end
  end

  // Node memory: next link and key, one port, registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      node_mem[nodes_used_r[AW-1:0]] <= {head_q_r, key_r};
    end
    if (state_r == S_NRD) begin
      node_q_r <= node_mem[cur_r[AW-1:0]];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_r          <= '0;
      bucket_count_r <= BUCKET_COUNT_RESET;
      nodes_used_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // Take configuration beats at any time
      if (cfg_wr.valid) begin
        bucket_count_r <= cfg_wr.bucket_count;
      end

      // Drop the response once taken, unless a new one replaces it
      if (out_valid_r && out_rsp.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + BW'(1);
          if (clr_r == LAST_BKT) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_req.valid) begin
            opcode_r <= in_req.opcode;
            key_r    <= in_req.key;
            key_sh_r <= KP'(in_req.key);
            rem_r    <= '0;
            dig_r    <= '0;
            div_r    <= div_eff;
            state_r  <= S_DIV;
          end
        end

        S_DIV: begin
          rem_r    <= rem_nxt;
          key_sh_r <= key_sh_r << DIGIT_BITS;
          dig_r    <= dig_r + DCW'(1);
          if (dig_r == LAST_DIG) begin
            bucket_r <= BW'(rem_nxt);
            state_r  <= S_HRD;
          end
        end

        S_HRD: begin
          if (opcode_r == OP_INSERT && nodes_used_r == NULL_NODE) begin
            res_status_r <= ST_FULL;
            res_index_r  <= '0;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_HCHK;
          end
        end

        S_HCHK: begin
          if (opcode_r == OP_INSERT) begin
            nodes_used_r <= nodes_used_r + NW'(1);
            res_status_r <= ST_INSERTED;
            res_index_r  <= nodes_used_r;
            state_r      <= S_DONE;
          end else if (head_q_r < NULL_NODE) begin
            cur_r   <= head_q_r;
            steps_r <= '0;
            state_r <= S_NRD;
          end else begin
            res_status_r <= ST_NOT_FOUND;
            res_index_r  <= '0;
            state_r      <= S_DONE;
          end
        end

        S_NRD: begin
          state_r <= S_NCHK;
        end

        S_NCHK: begin
          if (node_key == key_r) begin
            res_status_r <= ST_FOUND;
            res_index_r  <= cur_r;
            state_r      <= S_DONE;
          end else if (node_next < NULL_NODE && steps_r != LAST_STEP) begin
            cur_r   <= node_next;
            steps_r <= steps_r + NW'(1);
            state_r <= S_NRD;
          end else begin
            res_status_r <= ST_NOT_FOUND;
            res_index_r  <= '0;
            state_r      <= S_DONE;
          end
        end

        S_DONE: begin
          // Load the response register once it is free
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_index_r  <= IDX_WIDTH'(res_index_r);
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  // Ports
  assign in_req.ready       = (state_r == S_IDLE);
  assign cfg_wr.ready       = 1'b1;
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.node_index = out_index_r;

endmodule

// ----- sv/chte_checker.sv -----
// ---------------------------------------------------------------------------
// chte_checker
// Port-level checks of the chained hash table engine, bound to the top.
// ---------------------------------------------------------------------------
module chte_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input chte_pkg::status_t              out_status,
  input logic [chte_pkg::IDX_WIDTH-1:0] out_node_index
);
  import chte_pkg::*;

  // Engine goes busy after taking a request beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  // Clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("request ready before bucket heads cleared");

  // Misses and refusals report node zero
  a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_FOUND || out_status == ST_FULL)
      |-> out_node_index == '0)
    else $error("nonzero node index on miss or full");

  // Hold a stalled response beat
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_node_index))
    else $error("response payload changed while stalled");

endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_status     (out_rsp.status),
  .out_node_index (out_rsp.node_index)
);
